// ===== sv/nps_pkg.sv =====
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants of the nearest point search block.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int COORD_BITS  = 24;
    localparam int IDX_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int INDEX_W     = 8;
    localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int FIELD_W     = 24;
    localparam int DIST_W      = 50;
    localparam int SQ_W        = 2 * COORD_BITS;
    localparam int POINT_W     = 3 * COORD_BITS;

    localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(64'd65536000000000);

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_NONE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== sv/nps_req_if.sv =====
// ----------------------------------------------------------------------------
// nps_req_if
// Request channel of the nearest point search block.
// ----------------------------------------------------------------------------
interface nps_req_if
    import nps_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [INDEX_W-1:0]         index;
    logic signed [FIELD_W-1:0]  x_pos;
    logic signed [FIELD_W-1:0]  y_pos;
    logic signed [FIELD_W-1:0]  z_pos;

    modport source (output valid, func, index, x_pos, y_pos, z_pos, input ready);
    modport sink   (input valid, func, index, x_pos, y_pos, z_pos, output ready);
endinterface

// ===== sv/nps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nps_rsp_if
// Response channel of the nearest point search block.
// ----------------------------------------------------------------------------
interface nps_rsp_if
    import nps_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [INDEX_W-1:0]     result_index;
    logic [DIST_W-1:0]      distance;

    modport source (output valid, status, result_index, distance, input ready);
    modport sink   (input valid, status, result_index, distance, output ready);
endinterface

// ===== sv/nps_ram.sv =====
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/nearest_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_point_search
// Point table with add, overwrite and brute-force nearest point query.
// ----------------------------------------------------------------------------
// req carries one item per handshake: func selects add, set or query, index
// names the entry for a set, x_pos/y_pos/z_pos are signed Q16.8 coordinates.
// rsp returns one item for each add, set or query: status, result_index and
// the squared distance in Q34.16. An item with func 3 is taken and dropped.
// cfg_we/cfg_wdata load the starting best distance of a query.
// An add or set passes from idle to the done state and waits there until the
// output register is free. A query scans the N stored points (none for an
// empty table) before its result is loaded:
// the point memory has one read port and the scan reads one entry per
// cycle through a four-stage datapath (difference, square, sum, compare).
// One item is in work at a time; req is ready again once its result is in
// the output register, so a stalled rsp holds one finished item while the
// next one is worked on, and stalls req only after that.
// Reset empties the table and loads the limit with 1e9 units squared; the
// stored points are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module nearest_point_search
    import nps_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    nps_req_if.sink         req,
    nps_rsp_if.source       rsp,
    input  logic            cfg_we,
    input  logic [DIST_W-1:0] cfg_wdata
);
    state_t state_reg, state_next;

    logic [DIST_W-1:0]  limit_reg;
    logic [CNT_W-1:0]   point_count_reg;
    logic [CNT_W-1:0]   scan_reg;

    logic signed [COORD_BITS-1:0] q_x_reg, q_y_reg, q_z_reg;

    logic               rd_vld_reg, dif_vld_reg, sq_vld_reg, sum_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg, dif_idx_reg, sq_idx_reg, sum_idx_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]  sum_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic               found_reg;

    status_t            res_status_reg;
    logic [INDEX_W-1:0] res_index_reg;
    logic [DIST_W-1:0]  res_dist_reg;

    logic               rsp_vld_reg;
    status_t            rsp_status_reg;
    logic [INDEX_W-1:0] rsp_index_reg;
    logic [DIST_W-1:0]  rsp_dist_reg;

    logic               accept;
    logic               issue;
    logic               scan_end;
    logic               load_rsp;
    logic               full;
    logic               in_range;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   cnt_ext;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [POINT_W-1:0] ram_wdata;
    logic [POINT_W-1:0] ram_rdata;

    logic signed [COORD_BITS-1:0] in_x, in_y, in_z;
    logic signed [COORD_BITS-1:0] p_x, p_y, p_z;
    logic signed [COORD_BITS:0]   dx_s, dy_s, dz_s;
    logic [COORD_BITS-1:0]        dx_next, dy_next, dz_next;
    logic [SQ_W-1:0]              sqx_next, sqy_next, sqz_next;
    logic [DIST_W-1:0]            sum_next;

    // coordinates: low COORD_BITS bits, sign taken from the top one
    assign in_x = signed'(req.x_pos[COORD_BITS-1:0]);
    assign in_y = signed'(req.y_pos[COORD_BITS-1:0]);
    assign in_z = signed'(req.z_pos[COORD_BITS-1:0]);

    assign accept   = req.valid && req.ready;
    assign full     = (point_count_reg == CNT_W'(MAX_POINTS));
    assign idx_ext  = CMP_W'(req.index);
    assign cnt_ext  = CMP_W'(point_count_reg);
    assign in_range = (idx_ext < cnt_ext);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && req.func == FUNC_QUERY)
                begin
                    state_next = ST_SCAN;
                end
                else if (accept && (req.func == FUNC_ADD || req.func == FUNC_SET))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        req.ready = 1'b0;
        issue     = 1'b0;
        scan_end  = 1'b0;
        load_rsp  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_SCAN:
            begin
                issue    = (scan_reg < point_count_reg);
                scan_end = !issue && !rd_vld_reg && !dif_vld_reg
                           && !sq_vld_reg && !sum_vld_reg;
            end
            ST_DONE:
            begin
                load_rsp = !rsp_vld_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // table writes happen only at acceptance
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = point_count_reg[IDX_W-1:0];
        ram_wdata = {in_x, in_y, in_z};
        if (accept && req.func == FUNC_ADD && !full)
        begin
            ram_we = 1'b1;
        end
        else if (accept && req.func == FUNC_SET && in_range)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_ext[IDX_W-1:0];
        end
    end

    nps_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // distance datapath
    assign p_x = signed'(ram_rdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign p_y = signed'(ram_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign p_z = signed'(ram_rdata[COORD_BITS-1:0]);

    always_comb
    begin
        dx_s = {p_x[COORD_BITS-1], p_x} - {q_x_reg[COORD_BITS-1], q_x_reg};
        dy_s = {p_y[COORD_BITS-1], p_y} - {q_y_reg[COORD_BITS-1], q_y_reg};
        dz_s = {p_z[COORD_BITS-1], p_z} - {q_z_reg[COORD_BITS-1], q_z_reg};
        dx_next = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : COORD_BITS'(dx_s);
        dy_next = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : COORD_BITS'(dy_s);
        dz_next = dz_s[COORD_BITS] ? COORD_BITS'(-dz_s) : COORD_BITS'(dz_s);
        sqx_next = SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_next = SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sqz_next = SQ_W'(dz_reg) * SQ_W'(dz_reg);
        sum_next = DIST_W'(sqx_reg) + DIST_W'(sqy_reg) + DIST_W'(sqz_reg);
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= scan_reg[IDX_W-1:0];
        dif_idx_reg <= rd_idx_reg;
        sq_idx_reg  <= dif_idx_reg;
        sum_idx_reg <= sq_idx_reg;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        sqz_reg     <= sqz_next;
        sum_reg     <= sum_next;
    end

    // query point, running best and pending result
    always_ff @(posedge clk)
    begin
        if (accept && req.func == FUNC_QUERY)
        begin
            q_x_reg      <= in_x;
            q_y_reg      <= in_y;
            q_z_reg      <= in_z;
            best_reg     <= limit_reg;
            best_idx_reg <= '0;
        end
        else if (sum_vld_reg && sum_reg < best_reg)
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= sum_idx_reg;
        end

        if (accept && req.func == FUNC_ADD)
        begin
            res_status_reg <= full ? STAT_FULL : STAT_OK;
            res_index_reg  <= full ? '0 : INDEX_W'(point_count_reg);
            res_dist_reg   <= '0;
        end
        else if (accept && req.func == FUNC_SET)
        begin
            res_status_reg <= in_range ? STAT_OK : STAT_RANGE;
            res_index_reg  <= req.index;
            res_dist_reg   <= '0;
        end
        else if (scan_end)
        begin
            res_status_reg <= found_reg ? STAT_OK : STAT_NONE;
            res_index_reg  <= found_reg ? INDEX_W'(best_idx_reg) : '0;
            res_dist_reg   <= best_reg;
        end

        if (load_rsp)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_index_reg  <= res_index_reg;
            rsp_dist_reg   <= res_dist_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            limit_reg       <= LIMIT_RESET;
            point_count_reg <= '0;
            scan_reg        <= '0;
            rd_vld_reg      <= 1'b0;
            dif_vld_reg     <= 1'b0;
            sq_vld_reg      <= 1'b0;
            sum_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            rsp_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            dif_vld_reg <= rd_vld_reg;
            sq_vld_reg  <= dif_vld_reg;
            sum_vld_reg <= sq_vld_reg;

            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            if (accept && req.func == FUNC_ADD && !full)
            begin
                point_count_reg <= point_count_reg + CNT_W'(1);
            end

            if (accept && req.func == FUNC_QUERY)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_reg <= scan_reg + CNT_W'(1);
                end
                if (sum_vld_reg && sum_reg < best_reg)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (load_rsp)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid        = rsp_vld_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_index = rsp_index_reg;
    assign rsp.distance     = rsp_dist_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        point_count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table size");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE)
        else $error("table written outside idle");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && state_next == ST_DONE)
        |-> !(rd_vld_reg || dif_vld_reg || sq_vld_reg || sum_vld_reg))
        else $error("scan ended with points still in the datapath");

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && $past(state_reg) == ST_SCAN) |-> best_reg <= limit_reg)
        else $error("running best above limit");

    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && found_reg) |-> CNT_W'(best_idx_reg) < point_count_reg)
        else $error("nearest entry outside filled range");
endmodule

// ===== verif/nearest_point_search_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_point_search_tb
// Self-checking bench for the nearest point search block. A scoreboard keeps
// its own copy of the point table and the distance limit, predicts the result
// of every accepted add, set and query item and compares each returned item
// field by field. Directed items cover an empty table, ties, exact
// matches and coordinate extremes; random phases run under several limits,
// with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module nearest_point_search_tb;
    import nps_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [FIELD_W-1:0] COORD_MAX  = 24'h7FFFFF;
    localparam logic [FIELD_W-1:0] COORD_MIN  = 24'h800000;
    localparam logic [DIST_W-1:0] LIMIT_MAX   = {DIST_W{1'b1}};
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = MAX_POINTS + 16;
    localparam int PHASE_ITEMS   = 230;

    typedef struct {
        status_t            status;
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
    } search_result_t;

    class search_scoreboard;
        logic [COORD_BITS-1:0] tab_x [MAX_POINTS];
        logic [COORD_BITS-1:0] tab_y [MAX_POINTS];
        logic [COORD_BITS-1:0] tab_z [MAX_POINTS];
        int unsigned           fill;
        logic [DIST_W-1:0]     limit;
        search_result_t        awaited [$];
        int                    mismatches;

        function new();
            fill       = 0;
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [DIST_W-1:0] square_term(logic [COORD_BITS-1:0] a,
                                                logic [COORD_BITS-1:0] b);
            logic [COORD_BITS:0] d;
            logic [COORD_BITS:0] m;
            d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            m = d[COORD_BITS] ? -d : d;
            return DIST_W'(m) * DIST_W'(m);
        endfunction

        function void push(status_t st, logic [INDEX_W-1:0] idx, logic [DIST_W-1:0] dist_val);
            search_result_t r;
            r.status   = st;
            r.index    = idx;
            r.distance = dist_val;
            awaited.push_back(r);
        endfunction

        function void search_table(logic [COORD_BITS-1:0] qx, logic [COORD_BITS-1:0] qy,
                                   logic [COORD_BITS-1:0] qz);
            logic [DIST_W-1:0] best;
            logic [DIST_W-1:0] d;
            int unsigned       best_idx;
            bit                found;
            best     = limit;
            best_idx = 0;
            found    = 0;
            for (int unsigned i = 0; i < fill; i++)
            begin
                d = square_term(tab_x[i], qx) + square_term(tab_y[i], qy)
                  + square_term(tab_z[i], qz);
                if (d < best)
                begin
                    best     = d;
                    best_idx = i;
                    found    = 1;
                end
            end
            if (found)
                push(STAT_OK, INDEX_W'(best_idx), best);
            else
                push(STAT_NONE, '0, best);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                                   logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                   logic [FIELD_W-1:0] z);
            logic [COORD_BITS-1:0] cx;
            logic [COORD_BITS-1:0] cy;
            logic [COORD_BITS-1:0] cz;
            cx = x[COORD_BITS-1:0];
            cy = y[COORD_BITS-1:0];
            cz = z[COORD_BITS-1:0];
            case (f)
                FUNC_ADD:
                begin
                    if (fill >= MAX_POINTS)
                        push(STAT_FULL, '0, '0);
                    else
                    begin
                        tab_x[fill] = cx;
                        tab_y[fill] = cy;
                        tab_z[fill] = cz;
                        push(STAT_OK, INDEX_W'(fill), '0);
                        fill++;
                    end
                end
                FUNC_SET:
                begin
                    if (idx >= fill)
                        push(STAT_RANGE, idx, '0);
                    else
                    begin
                        tab_x[idx] = cx;
                        tab_y[idx] = cy;
                        tab_z[idx] = cz;
                        push(STAT_OK, idx, '0);
                    end
                end
                FUNC_QUERY:
                    search_table(cx, cy, cz);
                default:
                    ;
            endcase
        endfunction

        function void check_response(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                                     logic [DIST_W-1:0] dist_val);
            search_result_t e;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: status %0d index %0d distance %0d",
                             st, idx, dist_val);
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status || idx !== e.index || dist_val !== e.distance)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: status %0d/%0d index %0d/%0d distance %0d/%0d",
                             e.status, st, e.index, idx, e.distance, dist_val);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [DIST_W-1:0] cfg_wdata;

    nps_req_if req_if ();
    nps_rsp_if rsp_if ();

    nearest_point_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    search_scoreboard sb = new();

    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int mode_left  = 0;
    int idle_count = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // accepted and returned items
    always @(posedge clk)
    begin
        if (rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.func, req_if.index, req_if.x_pos, req_if.y_pos,
                            req_if.z_pos);
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.status, rsp_if.result_index, rsp_if.distance);
    end

    // response side stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(50, 400);
        end
        else
            mode_left <= mode_left - 1;
        if (stall_left != 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if (stall_mode == 1 && $urandom_range(0, 3) == 0)
                stall_left <= $urandom_range(1, 4);
            else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
                stall_left <= $urandom_range(5, 40);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
                             logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                             logic [FIELD_W-1:0] z);
        pace_sender();
        req_if.valid <= 1'b1;
        req_if.func  <= f;
        req_if.index <= idx;
        req_if.x_pos <= x;
        req_if.y_pos <= y;
        req_if.z_pos <= z;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(logic [DIST_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.limit = value;
    endtask

    function automatic logic [FIELD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return FIELD_W'($urandom_range(0, 1023)) - FIELD_W'(512);
            3: return $urandom_range(0, 1) ? '0 : '1;
            default: return FIELD_W'($urandom());
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] nudge(logic [COORD_BITS-1:0] base);
        int unsigned span;
        span = 1 << $urandom_range(0, 20);
        return FIELD_W'($signed(base)) + FIELD_W'($urandom_range(0, 2 * span)) - FIELD_W'(span);
    endfunction

    task automatic run_phase(int count);
        logic [FUNC_W-1:0]  f;
        logic [INDEX_W-1:0] idx;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [FIELD_W-1:0] z;
        int                 sent;
        int                 r;
        int unsigned        pick;
        sent = 0;
        while (sent < count)
        begin
            r   = $urandom_range(0, 99);
            idx = INDEX_W'($urandom());
            x   = pick_coord();
            y   = pick_coord();
            z   = pick_coord();
            if (r < 28)
                f = FUNC_ADD;
            else if (r < 55)
            begin
                f = FUNC_SET;
                if (sb.fill > 0 && $urandom_range(0, 6) != 0)
                    idx = INDEX_W'($urandom_range(0, sb.fill - 1));
            end
            else if (r < 95)
            begin
                f = FUNC_QUERY;
                if (sb.fill > 0 && $urandom_range(0, 1) == 1)
                begin
                    pick = $urandom_range(0, sb.fill - 1);
                    x = nudge(sb.tab_x[pick]);
                    y = nudge(sb.tab_y[pick]);
                    z = nudge(sb.tab_z[pick]);
                end
            end
            else
                f = FUNC_UNUSED;
            if (f != FUNC_UNUSED)
                sent++;
            send_item(f, idx, x, y, z);
        end
    endtask

    initial
    begin
        req_if.valid = 1'b0;
        req_if.func  = FUNC_ADD;
        req_if.index = '0;
        req_if.x_pos = '0;
        req_if.y_pos = '0;
        req_if.z_pos = '0;
        rsp_if.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then extremes, ties and range checks
        send_item(FUNC_QUERY, '0, '0, '0, '0);
        send_item(FUNC_SET, '0, '1, '1, '1);
        send_item(FUNC_ADD, '1, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(FUNC_ADD, '0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(FUNC_ADD, '0, '0, '0, '0);
        send_item(FUNC_ADD, '0, '0, '0, '0);
        send_item(FUNC_QUERY, '0, '0, '0, '0);
        send_item(FUNC_QUERY, '1, 24'd1, '0, '0);
        send_item(FUNC_SET, 8'd3, '1, '1, '1);
        send_item(FUNC_SET, 8'd4, '0, '0, '0);
        send_item(FUNC_SET, 8'd255, COORD_MAX, '0, COORD_MIN);
        send_item(FUNC_QUERY, '0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(FUNC_QUERY, '0, COORD_MIN, COORD_MAX, '0);
        send_item(FUNC_UNUSED, '1, '1, '1, '1);
        send_item(FUNC_QUERY, '0, COORD_MAX, COORD_MIN, COORD_MAX);

        // largest distance, all entries tied
        write_limit(LIMIT_MAX);
        send_item(FUNC_SET, 8'd0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(FUNC_SET, 8'd2, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(FUNC_SET, 8'd3, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(FUNC_QUERY, '0, COORD_MAX, COORD_MAX, COORD_MAX);

        write_limit('0);
        send_item(FUNC_QUERY, '0, COORD_MIN, COORD_MIN, COORD_MIN);

        write_limit(DIST_W'(1));
        send_item(FUNC_QUERY, '0, COORD_MIN, COORD_MIN, COORD_MIN);

        // random phases under a spread of limits
        write_limit(LIMIT_MAX);
        run_phase(PHASE_ITEMS);
        write_limit(DIST_W'($urandom_range(0, 1 << 20)));
        run_phase(PHASE_ITEMS);
        write_limit(LIMIT_RESET);
        run_phase(PHASE_ITEMS);
        write_limit(DIST_W'({$urandom(), $urandom()}));
        run_phase(PHASE_ITEMS);
        write_limit('0);
        run_phase(PHASE_ITEMS / 2);
        write_limit(DIST_W'({$urandom_range(0, 3), $urandom()}));
        run_phase(PHASE_ITEMS);
        write_limit(LIMIT_MAX);
        run_phase(PHASE_ITEMS / 2);

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
